// ----- src/lwsm_pkg.sv -----
// ----------------------------------------------------------------------------
// lwsm_pkg
// Shared types and constants of the latency window statistics monitor.
// ----------------------------------------------------------------------------
package lwsm_pkg;

	localparam int LAT_W  = 24;
	localparam int CNT_W  = 32;
	localparam int BYTE_W = 48;
	localparam int CPU_W  = 7;
	localparam int MSG_W  = 24;
	localparam int CFG_W  = 48;
	localparam int IDX_W  = 2;

	// reciprocal of 100 for the percentile index, exact for products below 2^24
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;
	localparam logic [6:0] PCT_95 = 7'd95;
	localparam logic [6:0] PCT_99 = 7'd99;

	typedef enum logic [2:0] {
		OP_CONNECT    = 3'd0,
		OP_DISCONNECT = 3'd1,
		OP_MSG_RECV   = 3'd2,
		OP_MSG_SENT   = 3'd3,
		OP_LATENCY    = 3'd4,
		OP_MEMORY     = 3'd5,
		OP_TICK       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_CONN_LIMIT = 2'd0,
		CFG_LAT_LIMIT  = 2'd1,
		CFG_MEM_LIMIT  = 2'd2,
		CFG_CPU_LIMIT  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROT,
		ST_SCAN,
		ST_DIV
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic [MSG_W-1:0]  message_bytes;
		logic [LAT_W-1:0]  latency_us;
		logic [BYTE_W-1:0] memory_bytes;
		logic [CPU_W-1:0]  cpu_percent;
	} lwsm_in_t;

	typedef struct packed {
		logic [CNT_W-1:0]        active_count;
		logic [CNT_W-1:0]        peak_count;
		logic signed [CNT_W-1:0] connection_delta;
		logic [CNT_W-1:0]        received_msg_delta;
		logic [BYTE_W-1:0]       received_byte_delta;
		logic [CNT_W-1:0]        sent_msg_delta;
		logic [LAT_W-1:0]        latency_mean_us;
		logic [LAT_W-1:0]        latency_p95_us;
		logic [LAT_W-1:0]        latency_p99_us;
		logic [BYTE_W-1:0]       memory_now_bytes;
		logic [BYTE_W-1:0]       memory_peak_out;
		logic [3:0]              alert_mask;
	} lwsm_out_t;

	// per-cycle control broadcast along the cell row
	typedef struct packed {
		logic ring_en;
		logic srt_clr;
		logic srt_ins;
		logic srt_shift;
	} lwsm_cell_ctl_t;

endpackage

// ----- src/lwsm_cell.sv -----
// ----------------------------------------------------------------------------
// lwsm_cell
// One cell of the row: a window sample stage and an insertion sort stage.
// ----------------------------------------------------------------------------
module lwsm_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lwsm_pkg::lwsm_cell_ctl_t     ctl,
	input  logic [lwsm_pkg::LAT_W-1:0]   ring_in,
	input  logic [lwsm_pkg::LAT_W-1:0]   key_x,
	input  logic [lwsm_pkg::LAT_W-1:0]   prev_key,
	input  logic                         prev_cmp,
	input  logic                         prev_vld,
	input  logic [lwsm_pkg::LAT_W-1:0]   next_key,
	output logic [lwsm_pkg::LAT_W-1:0]   ring_q,
	output logic [lwsm_pkg::LAT_W-1:0]   key_q,
	output logic                         vld_q,
	output logic                         cmp
);

	// new key goes at or before this cell
	assign cmp = !vld_q || (key_x < key_q);

	// window sample stage
	always_ff @(posedge clk) begin
		if (ctl.ring_en) begin
			ring_q <= ring_in;
		end
	end

	// sorted key occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.srt_clr) begin
			vld_q <= 1'b0;
		end else if (ctl.srt_ins && cmp) begin
			vld_q <= prev_cmp ? prev_vld : 1'b1;
		end
	end

	// sorted key: take the new key, the left key, or shift down on scan
	always_ff @(posedge clk) begin
		if (ctl.srt_ins && cmp) begin
			key_q <= prev_cmp ? prev_key : key_x;
		end else if (ctl.srt_shift) begin
			key_q <= next_key;
		end
	end

endmodule

// ----- src/lwsm_div.sv -----
// ----------------------------------------------------------------------------
// lwsm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwsm_div #(
	parameter int DW = 32,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW:0]   rem_sh;
	logic [VW:0]   rem_sub;
	logic          fits;

	// trial subtract of the shifted remainder
	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, divisor};
	assign fits    = rem_sh >= {1'b0, divisor};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/latency_window_stats_monitor_core.sv -----
// ----------------------------------------------------------------------------
// latency_window_stats_monitor_core
// Event counters, memory watermark and a sliding latency window with mean
// and percentile report on each tick.
// ----------------------------------------------------------------------------
// Every operation other than a tick is taken while busy stays low, so a new
// command may follow in the next cycle. A tick raises busy while the window
// samples circulate once around the cell row and the newest fill_q of them
// are inserted into the sorted row, the sorted row is shifted out past the
// percentile indexes, and the divider forms the mean of the SUMW-bit window
// sum (SUMW = 24 + log2 WINDOW) one bit per cycle. The report appears on
// result for one cycle with done high, in the first cycle after busy falls,
// and cannot be held off. There is no clearing pass after reset.
module latency_window_stats_monitor_core #(
	parameter int WINDOW = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  lwsm_pkg::lwsm_in_t             req,
	output logic                           done,
	output lwsm_pkg::lwsm_out_t            result,
	input  logic                           cfg_we,
	input  logic [lwsm_pkg::IDX_W-1:0]     cfg_addr,
	input  logic [lwsm_pkg::CFG_W-1:0]     cfg_data
);

	localparam int LW   = lwsm_pkg::LAT_W;
	localparam int RW   = $clog2(WINDOW);
	localparam int NW   = $clog2(WINDOW + 1);
	localparam int SUMW = LW + RW;
	localparam int PW   = NW + 7;
	localparam int MW   = PW + lwsm_pkg::RECIP_W;

	lwsm_pkg::state_t state_q, state_d;

	logic [lwsm_pkg::CNT_W-1:0]  conn_limit_q;
	logic [LW-1:0]               lat_limit_q;
	logic [lwsm_pkg::BYTE_W-1:0] mem_limit_q;
	logic [lwsm_pkg::CPU_W-1:0]  cpu_limit_q;

	logic [lwsm_pkg::CNT_W-1:0]  active_q, peak_q, recv_msgs_q, sent_msgs_q;
	logic [lwsm_pkg::BYTE_W-1:0] recv_bytes_q, mem_cur_q, mem_peak_q;
	logic [lwsm_pkg::CNT_W-1:0]  snap_active_q, snap_recv_q, snap_sent_q;
	logic [lwsm_pkg::BYTE_W-1:0] snap_bytes_q;
	logic [NW-1:0]               fill_q;
	logic [lwsm_pkg::CPU_W-1:0]  cpu_q;
	logic [lwsm_pkg::CNT_W-1:0]  active_inc;

	logic [RW-1:0]   rot_q, scan_q;
	logic [SUMW-1:0] sum_q;
	logic [LW-1:0]   p95_q, p99_q;
	logic [PW-1:0]   k95_s1, k99_s1;
	logic [NW-1:0]   k95_s2, k99_s2;
	logic [MW-1:0]   m95, m99;
	logic [NW:0]     rot_pos;

	logic                     accept, is_tick;
	logic                     rot_last, scan_last, rot_ins;
	lwsm_pkg::lwsm_cell_ctl_t ctl;
	logic [LW-1:0]            ring_feed;
	logic                     div_start, div_done;
	logic [SUMW-1:0]          div_quo;
	lwsm_pkg::lwsm_out_t      res_d, result_q;
	logic                     done_q;
	logic [LW-1:0]            mean;

	logic [LW-1:0] ring_arr [WINDOW];
	logic [LW-1:0] key_arr  [WINDOW];
	logic          vld_arr  [WINDOW];
	logic          cmp_arr  [WINDOW];

	assign accept  = start && !busy;
	assign is_tick = req.operation == lwsm_pkg::OP_TICK;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_limit_q <= '1;
			lat_limit_q  <= '1;
			mem_limit_q  <= '1;
			cpu_limit_q  <= 7'd100;
		end else if (cfg_we) begin
			case (cfg_addr)
				lwsm_pkg::CFG_CONN_LIMIT: conn_limit_q <= cfg_data[lwsm_pkg::CNT_W-1:0];
				lwsm_pkg::CFG_LAT_LIMIT:  lat_limit_q  <= cfg_data[LW-1:0];
				lwsm_pkg::CFG_MEM_LIMIT:  mem_limit_q  <= cfg_data[lwsm_pkg::BYTE_W-1:0];
				lwsm_pkg::CFG_CPU_LIMIT:  cpu_limit_q  <= cfg_data[lwsm_pkg::CPU_W-1:0];
				default: ;
			endcase
		end
	end

	assign active_inc = active_q + {31'd0, active_q != '1};

	// event counters and tick snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= '0;
			peak_q        <= '0;
			recv_msgs_q   <= '0;
			sent_msgs_q   <= '0;
			recv_bytes_q  <= '0;
			mem_cur_q     <= '0;
			mem_peak_q    <= '0;
			fill_q        <= '0;
			snap_active_q <= '0;
			snap_recv_q   <= '0;
			snap_sent_q   <= '0;
			snap_bytes_q  <= '0;
		end else if (div_done) begin
			snap_active_q <= active_q;
			snap_recv_q   <= recv_msgs_q;
			snap_sent_q   <= sent_msgs_q;
			snap_bytes_q  <= recv_bytes_q;
		end else if (accept) begin
			case (req.operation)
				lwsm_pkg::OP_CONNECT: begin
					active_q <= active_inc;
					if (active_inc > peak_q) begin
						peak_q <= active_inc;
					end
				end
				lwsm_pkg::OP_DISCONNECT: begin
					if (active_q != '0) begin
						active_q <= active_q - 1'b1;
					end
				end
				lwsm_pkg::OP_MSG_RECV: begin
					recv_msgs_q  <= recv_msgs_q + 1'b1;
					recv_bytes_q <= recv_bytes_q +
						lwsm_pkg::BYTE_W'(req.message_bytes);
				end
				lwsm_pkg::OP_MSG_SENT: sent_msgs_q <= sent_msgs_q + 1'b1;
				lwsm_pkg::OP_LATENCY: begin
					if (fill_q != NW'(WINDOW)) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				lwsm_pkg::OP_MEMORY: begin
					mem_cur_q <= req.memory_bytes;
					if (req.memory_bytes > mem_peak_q) begin
						mem_peak_q <= req.memory_bytes;
					end
				end
				lwsm_pkg::OP_CLEAR: begin
					active_q      <= '0;
					peak_q        <= '0;
					recv_msgs_q   <= '0;
					sent_msgs_q   <= '0;
					recv_bytes_q  <= '0;
					mem_cur_q     <= '0;
					mem_peak_q    <= '0;
					fill_q        <= '0;
					snap_active_q <= '0;
					snap_recv_q   <= '0;
					snap_sent_q   <= '0;
					snap_bytes_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lwsm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign rot_last  = rot_q == RW'(WINDOW - 1);
	assign scan_last = scan_q == RW'(WINDOW - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lwsm_pkg::ST_IDLE: if (accept && is_tick) state_d = lwsm_pkg::ST_ROT;
			lwsm_pkg::ST_ROT:  if (rot_last) state_d = lwsm_pkg::ST_SCAN;
			lwsm_pkg::ST_SCAN: if (scan_last) state_d = lwsm_pkg::ST_DIV;
			lwsm_pkg::ST_DIV:  if (div_done) state_d = lwsm_pkg::ST_IDLE;
			default:           state_d = lwsm_pkg::ST_IDLE;
		endcase
	end

	// only the newest fill_q samples join the sort as they leave the last cell
	assign rot_pos = (NW+1)'(rot_q) + (NW+1)'(fill_q);
	assign rot_ins = rot_pos >= (NW+1)'(WINDOW);

	// sequencer outputs
	always_comb begin
		busy          = state_q != lwsm_pkg::ST_IDLE;
		ctl.ring_en   = 1'b0;
		ctl.srt_clr   = 1'b0;
		ctl.srt_ins   = 1'b0;
		ctl.srt_shift = 1'b0;
		ring_feed     = req.latency_us;
		div_start     = 1'b0;
		case (state_q)
			lwsm_pkg::ST_IDLE: begin
				ctl.ring_en = accept && req.operation == lwsm_pkg::OP_LATENCY;
				ctl.srt_clr = accept && is_tick;
			end
			lwsm_pkg::ST_ROT: begin
				ctl.ring_en = 1'b1;
				ctl.srt_ins = rot_ins;
				ring_feed   = ring_arr[WINDOW-1];
			end
			lwsm_pkg::ST_SCAN: begin
				ctl.srt_shift = 1'b1;
				div_start     = scan_last;
			end
			default: ;
		endcase
	end

	// rotation and scan counters, window sum and percentile capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q  <= '0;
			scan_q <= '0;
		end else begin
			rot_q  <= (state_q == lwsm_pkg::ST_ROT) ? rot_q + 1'b1 : '0;
			scan_q <= (state_q == lwsm_pkg::ST_SCAN) ? scan_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.srt_clr) begin
			sum_q <= '0;
			cpu_q <= req.cpu_percent;
		end else if (ctl.srt_ins) begin
			sum_q <= sum_q + SUMW'(ring_arr[WINDOW-1]);
		end
		if (ctl.srt_shift && NW'(scan_q) == k95_s2) begin
			p95_q <= key_arr[0];
		end
		if (ctl.srt_shift && NW'(scan_q) == k99_s2) begin
			p99_q <= key_arr[0];
		end
	end

	// percentile indexes n*95/100 and n*99/100 by reciprocal multiply
	assign m95 = MW'(k95_s1) * MW'(lwsm_pkg::RECIP_100);
	assign m99 = MW'(k99_s1) * MW'(lwsm_pkg::RECIP_100);

	always_ff @(posedge clk) begin
		k95_s1 <= PW'(fill_q) * PW'(lwsm_pkg::PCT_95);
		k99_s1 <= PW'(fill_q) * PW'(lwsm_pkg::PCT_99);
		k95_s2 <= m95[lwsm_pkg::RECIP_SHIFT +: NW];
		k99_s2 <= m99[lwsm_pkg::RECIP_SHIFT +: NW];
	end

	// row of cells
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		logic [LW-1:0] ring_in_w, prev_key_w, next_key_w;
		logic          prev_cmp_w, prev_vld_w;

		if (i == 0) begin : g_head
			assign ring_in_w  = ring_feed;
			assign prev_key_w = '0;
			assign prev_cmp_w = 1'b0;
			assign prev_vld_w = 1'b0;
		end else begin : g_body
			assign ring_in_w  = ring_arr[i-1];
			assign prev_key_w = key_arr[i-1];
			assign prev_cmp_w = cmp_arr[i-1];
			assign prev_vld_w = vld_arr[i-1];
		end

		if (i == WINDOW - 1) begin : g_tail
			assign next_key_w = key_arr[i];
		end else begin : g_mid
			assign next_key_w = key_arr[i+1];
		end

		lwsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.ring_in  (ring_in_w),
			.key_x    (ring_arr[WINDOW-1]),
			.prev_key (prev_key_w),
			.prev_cmp (prev_cmp_w),
			.prev_vld (prev_vld_w),
			.next_key (next_key_w),
			.ring_q   (ring_arr[i]),
			.key_q    (key_arr[i]),
			.vld_q    (vld_arr[i]),
			.cmp      (cmp_arr[i])
		);
	end

	// mean of the window
	lwsm_div #(
		.DW (SUMW),
		.VW (NW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign mean = (fill_q == '0) ? '0 : div_quo[LW-1:0];

	// report assembly
	always_comb begin
		res_d.active_count        = active_q;
		res_d.peak_count          = peak_q;
		res_d.connection_delta    = active_q - snap_active_q;
		res_d.received_msg_delta  = recv_msgs_q - snap_recv_q;
		res_d.received_byte_delta = recv_bytes_q - snap_bytes_q;
		res_d.sent_msg_delta      = sent_msgs_q - snap_sent_q;
		res_d.latency_mean_us     = mean;
		res_d.latency_p95_us      = (fill_q == '0) ? '0 : p95_q;
		res_d.latency_p99_us      = (fill_q == '0) ? '0 : p99_q;
		res_d.memory_now_bytes    = mem_cur_q;
		res_d.memory_peak_out     = mem_peak_q;
		res_d.alert_mask          = {cpu_q > cpu_limit_q, mem_cur_q > mem_limit_q,
			mean > lat_limit_q, active_q > conn_limit_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_done;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NW'(WINDOW))
		else $error("window fill count beyond window");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.operation == lwsm_pkg::OP_TICK) |=> busy)
		else $error("tick transfer did not start the report");

	a_pct_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.latency_p95_us <= result.latency_p99_us)
		else $error("95th percentile above 99th");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives connection, message, latency, memory, tick and clear commands into
// the monitor core and checks every tick report against a software model of
// the counters, the latency window and the alert limits.
// ----------------------------------------------------------------------------

class lwsm_scoreboard;
	// limits
	logic [lwsm_pkg::CNT_W-1:0]  conn_limit;
	logic [lwsm_pkg::LAT_W-1:0]  lat_limit;
	logic [lwsm_pkg::BYTE_W-1:0] mem_limit;
	logic [lwsm_pkg::CPU_W-1:0]  cpu_limit;
	// monitor state
	logic [lwsm_pkg::CNT_W-1:0]  active;
	logic [lwsm_pkg::CNT_W-1:0]  peak;
	logic [lwsm_pkg::CNT_W-1:0]  recv_msgs;
	logic [lwsm_pkg::CNT_W-1:0]  sent_msgs;
	logic [lwsm_pkg::BYTE_W-1:0] recv_bytes;
	logic [lwsm_pkg::CNT_W-1:0]  last_active;
	logic [lwsm_pkg::CNT_W-1:0]  last_recv_msgs;
	logic [lwsm_pkg::BYTE_W-1:0] last_recv_bytes;
	logic [lwsm_pkg::CNT_W-1:0]  last_sent_msgs;
	logic [lwsm_pkg::LAT_W-1:0]  window_buf [256];
	int unsigned                 head;
	int unsigned                 fill;
	logic [lwsm_pkg::BYTE_W-1:0] mem_now;
	logic [lwsm_pkg::BYTE_W-1:0] mem_peak;
	lwsm_pkg::lwsm_out_t         pending_reports [$];
	int                          errors;

	function new();
		conn_limit = '1;
		lat_limit  = '1;
		mem_limit  = '1;
		cpu_limit  = 7'd100;
		errors     = 0;
		clear_all();
	endfunction

	function void clear_all();
		active = '0; peak = '0; recv_msgs = '0; sent_msgs = '0; recv_bytes = '0;
		last_active = '0; last_recv_msgs = '0; last_recv_bytes = '0; last_sent_msgs = '0;
		head = 0; fill = 0; mem_now = '0; mem_peak = '0;
	endfunction

	function void set_limit(lwsm_pkg::cfg_idx_t idx, logic [lwsm_pkg::CFG_W-1:0] value);
		case (idx)
			lwsm_pkg::CFG_CONN_LIMIT: conn_limit = value[lwsm_pkg::CNT_W-1:0];
			lwsm_pkg::CFG_LAT_LIMIT:  lat_limit  = value[lwsm_pkg::LAT_W-1:0];
			lwsm_pkg::CFG_MEM_LIMIT:  mem_limit  = value[lwsm_pkg::BYTE_W-1:0];
			lwsm_pkg::CFG_CPU_LIMIT:  cpu_limit  = value[lwsm_pkg::CPU_W-1:0];
			default: ;
		endcase
	endfunction

	// update the model on one accepted transfer, queue a report on tick
	function void note_input(lwsm_pkg::lwsm_in_t cmd);
		logic [lwsm_pkg::LAT_W-1:0] sorted [$];
		logic [63:0]                sum;
		lwsm_pkg::lwsm_out_t        rep;
		sorted = {};
		sum = '0;
		case (cmd.operation)
			lwsm_pkg::OP_CONNECT: begin
				if (active != '1) active++;
				if (active > peak) peak = active;
			end
			lwsm_pkg::OP_DISCONNECT: if (active != '0) active--;
			lwsm_pkg::OP_MSG_RECV: begin
				recv_msgs++;
				recv_bytes = recv_bytes + lwsm_pkg::BYTE_W'(cmd.message_bytes);
			end
			lwsm_pkg::OP_MSG_SENT: sent_msgs++;
			lwsm_pkg::OP_LATENCY: begin
				window_buf[head] = cmd.latency_us;
				head = (head + 1) % 256;
				if (fill < 256) fill++;
			end
			lwsm_pkg::OP_MEMORY: begin
				mem_now = cmd.memory_bytes;
				if (cmd.memory_bytes > mem_peak) mem_peak = cmd.memory_bytes;
			end
			lwsm_pkg::OP_CLEAR: clear_all();
			lwsm_pkg::OP_TICK: begin
				rep = '0;
				if (fill > 0) begin
					for (int i = 0; i < fill; i++) begin
						sorted = {sorted, window_buf[i]};
						sum = sum + 64'(window_buf[i]);
					end
					sorted.sort();
					rep.latency_mean_us = lwsm_pkg::LAT_W'(sum / 64'(fill));
					rep.latency_p95_us  = sorted[fill * 95 / 100];
					rep.latency_p99_us  = sorted[fill * 99 / 100];
				end
				rep.active_count        = active;
				rep.peak_count          = peak;
				rep.connection_delta    = active - last_active;
				rep.received_msg_delta  = recv_msgs - last_recv_msgs;
				rep.received_byte_delta = recv_bytes - last_recv_bytes;
				rep.sent_msg_delta      = sent_msgs - last_sent_msgs;
				rep.memory_now_bytes    = mem_now;
				rep.memory_peak_out     = mem_peak;
				rep.alert_mask[0] = active > conn_limit;
				rep.alert_mask[1] = rep.latency_mean_us > lat_limit;
				rep.alert_mask[2] = mem_now > mem_limit;
				rep.alert_mask[3] = cmd.cpu_percent > cpu_limit;
				last_active = active; last_recv_msgs = recv_msgs;
				last_recv_bytes = recv_bytes; last_sent_msgs = sent_msgs;
				pending_reports = {pending_reports, rep};
			end
			default: ;
		endcase
	endfunction

	function void cmp_field(string name, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			errors++;
		end
	endfunction

	function void check_result(lwsm_pkg::lwsm_out_t got);
		lwsm_pkg::lwsm_out_t exp;
		if (pending_reports.size() == 0) begin
			$error("report with no tick outstanding");
			errors++;
			return;
		end
		exp = pending_reports.pop_front();
		cmp_field("active_count", 64'(exp.active_count), 64'(got.active_count));
		cmp_field("peak_count", 64'(exp.peak_count), 64'(got.peak_count));
		cmp_field("connection_delta", 64'(exp.connection_delta),
			64'(got.connection_delta));
		cmp_field("received_msg_delta", 64'(exp.received_msg_delta),
			64'(got.received_msg_delta));
		cmp_field("received_byte_delta", 64'(exp.received_byte_delta),
			64'(got.received_byte_delta));
		cmp_field("sent_msg_delta", 64'(exp.sent_msg_delta), 64'(got.sent_msg_delta));
		cmp_field("latency_mean_us", 64'(exp.latency_mean_us), 64'(got.latency_mean_us));
		cmp_field("latency_p95_us", 64'(exp.latency_p95_us), 64'(got.latency_p95_us));
		cmp_field("latency_p99_us", 64'(exp.latency_p99_us), 64'(got.latency_p99_us));
		cmp_field("memory_now_bytes", 64'(exp.memory_now_bytes),
			64'(got.memory_now_bytes));
		cmp_field("memory_peak_out", 64'(exp.memory_peak_out), 64'(got.memory_peak_out));
		cmp_field("alert_mask", 64'(exp.alert_mask), 64'(got.alert_mask));
	endfunction
endclass

module testbench;
	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	lwsm_pkg::lwsm_in_t           req = '0;
	logic                         done;
	lwsm_pkg::lwsm_out_t          result;
	logic                         cfg_we = 1'b0;
	logic [lwsm_pkg::IDX_W-1:0]   cfg_addr = '0;
	logic [lwsm_pkg::CFG_W-1:0]   cfg_data = '0;
	lwsm_scoreboard               sb = new();
	int unsigned                  cycles = 0;
	bit                           calm = 1'b0;

	latency_window_stats_monitor_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// report capture
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	// one command transfer, start left high afterwards
	task send_cmd(input lwsm_pkg::lwsm_in_t cmd);
		if (!calm && $urandom_range(99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		start <= 1'b1;
		req   <= cmd;
		do @(posedge clk); while (busy);
		sb.note_input(cmd);
		@(negedge clk);
	endtask

	task send_op(input lwsm_pkg::op_t op, input logic [lwsm_pkg::LAT_W-1:0] lat,
			input logic [lwsm_pkg::BYTE_W-1:0] mem,
			input logic [lwsm_pkg::CPU_W-1:0] cpu);
		lwsm_pkg::lwsm_in_t cmd;
		cmd.operation     = op;
		cmd.message_bytes = lwsm_pkg::MSG_W'($urandom);
		cmd.latency_us    = lat;
		cmd.memory_bytes  = mem;
		cmd.cpu_percent   = cpu;
		send_cmd(cmd);
	endtask

	// drain all reports and let the core settle
	task wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending_reports.size() != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task write_limit(input lwsm_pkg::cfg_idx_t idx,
			input logic [lwsm_pkg::CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(idx, value);
		@(negedge clk);
	endtask

	function automatic logic [lwsm_pkg::LAT_W-1:0] rand_latency();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 50) return lwsm_pkg::LAT_W'($urandom_range(1000));
		if (k < 80) return lwsm_pkg::LAT_W'($urandom);
		if (k < 90) return '0;
		return '1;
	endfunction

	function automatic lwsm_pkg::lwsm_in_t rand_cmd(bit allow_clear);
		lwsm_pkg::lwsm_in_t cmd;
		int unsigned        k;
		cmd.message_bytes = lwsm_pkg::MSG_W'($urandom);
		cmd.latency_us    = rand_latency();
		cmd.memory_bytes  = lwsm_pkg::BYTE_W'({$urandom, $urandom});
		if ($urandom_range(3) == 0)
			cmd.memory_bytes = lwsm_pkg::BYTE_W'($urandom_range(5000));
		cmd.cpu_percent = lwsm_pkg::CPU_W'($urandom_range(100));
		k = $urandom_range(99);
		if (k < 30)      cmd.operation = lwsm_pkg::OP_LATENCY;
		else if (k < 46) cmd.operation = lwsm_pkg::OP_CONNECT;
		else if (k < 58) cmd.operation = lwsm_pkg::OP_DISCONNECT;
		else if (k < 71) cmd.operation = lwsm_pkg::OP_MSG_RECV;
		else if (k < 80) cmd.operation = lwsm_pkg::OP_MSG_SENT;
		else if (k < 88) cmd.operation = lwsm_pkg::OP_MEMORY;
		else if (k < 96 || !allow_clear) cmd.operation = lwsm_pkg::OP_TICK;
		else if (k < 97) cmd.operation = lwsm_pkg::OP_CLEAR;
		else cmd.operation = lwsm_pkg::OP_TICK;
		return cmd;
	endfunction

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty window, floor at zero, extremes of each field
		calm = 1'b1;
		send_op(lwsm_pkg::OP_TICK, '0, '0, 7'd100);
		send_op(lwsm_pkg::OP_DISCONNECT, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_CONNECT, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_DISCONNECT, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_DISCONNECT, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_CONNECT, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_CONNECT, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_MSG_RECV, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_MSG_SENT, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_LATENCY, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_TICK, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_LATENCY, '1, '0, 7'd0);
		send_op(lwsm_pkg::OP_LATENCY, 24'd12345, '0, 7'd0);
		send_op(lwsm_pkg::OP_MEMORY, '0, '1, 7'd0);
		send_op(lwsm_pkg::OP_MEMORY, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_TICK, '0, '0, 7'd64);
		send_op(lwsm_pkg::OP_CLEAR, '0, '0, 7'd0);
		send_op(lwsm_pkg::OP_TICK, '0, '0, 7'd100);
		wait_idle();

		// phases over several limit settings
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_limit(lwsm_pkg::CFG_CONN_LIMIT, '0);
					write_limit(lwsm_pkg::CFG_LAT_LIMIT, '0);
					write_limit(lwsm_pkg::CFG_MEM_LIMIT, '0);
					write_limit(lwsm_pkg::CFG_CPU_LIMIT, '0);
				end
				2: begin
					write_limit(lwsm_pkg::CFG_CONN_LIMIT, 48'hFFFF_FFFF);
					write_limit(lwsm_pkg::CFG_LAT_LIMIT, 48'hFF_FFFF);
					write_limit(lwsm_pkg::CFG_MEM_LIMIT, '1);
					write_limit(lwsm_pkg::CFG_CPU_LIMIT, 48'd100);
				end
				default: begin
					write_limit(lwsm_pkg::CFG_CONN_LIMIT,
						lwsm_pkg::CFG_W'($urandom_range(6)));
					write_limit(lwsm_pkg::CFG_LAT_LIMIT,
						lwsm_pkg::CFG_W'($urandom_range(1 << 23)));
					write_limit(lwsm_pkg::CFG_MEM_LIMIT,
						lwsm_pkg::CFG_W'({$urandom, $urandom} >> $urandom_range(1)));
					write_limit(lwsm_pkg::CFG_CPU_LIMIT,
						lwsm_pkg::CFG_W'($urandom_range(100)));
				end
			endcase
			calm = (phase == 3);
			@(negedge clk);
			for (int i = 0; i < 140; i++)
				send_cmd(rand_cmd(phase != 2 && phase != 4));
			wait_idle();
		end

		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending_reports.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ----- files.f -----
src/lwsm_pkg.sv
src/lwsm_cell.sv
src/lwsm_div.sv
src/latency_window_stats_monitor_core.sv
tb/sv/testbench.sv
